>>> design/xcfc_pkg.sv
`default_nettype none

package xcfc_pkg;

  // Frame capacity and derived widths.
  localparam int MAX_BODY  = 256;
  localparam int BODY_W    = $clog2(MAX_BODY + 1);
  localparam int LENGTH_W  = 9;
  localparam int WORD_LEN  = 5;
  localparam int NUM_WORDS = 4;

  // Framing characters.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;

  // Verdict codes.
  localparam logic [1:0] VERDICT_OK       = 2'd0;
  localparam logic [1:0] VERDICT_BAD_SUM  = 2'd1;
  localparam logic [1:0] VERDICT_NO_STAR  = 2'd2;
  localparam logic [1:0] VERDICT_OVERFLOW = 2'd3;

  // Command codes.
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_PSIGN = 3'd1;
  localparam logic [2:0] CMD_PFLSH = 3'd2;
  localparam logic [2:0] CMD_PBLFL = 3'd3;
  localparam logic [2:0] CMD_PEEPR = 3'd4;

  // Command words; entry 0 is the highest priority. The first character of
  // each word sits in the top byte.
  localparam logic [NUM_WORDS-1:0][8*WORD_LEN-1:0] CMD_WORDS =
    {"PEEPR", "PBLFL", "PFLSH", "PSIGN"};

  // One result item as it leaves the frame tracker.
  typedef struct packed {
    logic [1:0]          verdict;
    logic [2:0]          command_code;
    logic [LENGTH_W-1:0] body_length;
    logic [7:0]          computed_checksum;
  } result_t;

  // Uppercase hex character of a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nibble);
    logic [7:0] ch;
    if (nibble < 4'd10) begin
      ch = 8'h30 + {4'h0, nibble};
    end else begin
      ch = 8'h37 + {4'h0, nibble};
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> design/xcfc_frame_tracker.sv
`default_nettype none

module xcfc_frame_tracker (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       byte_in,
  output logic                  close_hit,
  output xcfc_pkg::result_t     result
);

  // Frame state.
  logic                          in_frame, in_frame_next;
  logic [xcfc_pkg::BODY_W-1:0]   body_count, body_count_next;
  logic [7:0]                    xor_accumulator, xor_accumulator_next;
  logic                          star_seen, star_seen_next;
  logic [1:0]                    after_star_count, after_star_count_next;
  logic [7:0]                    hex_high_char, hex_high_char_next;
  logic [7:0]                    hex_low_char, hex_low_char_next;
  logic [xcfc_pkg::NUM_WORDS-1:0] prefix_match_flags, prefix_match_flags_next;
  logic                          overflowed, overflowed_next;

  logic       is_dollar;
  logic       is_nl;
  logic       body_full;
  logic       in_prefix;
  logic [2:0] char_index;
  logic [5:0] char_shift;
  logic       sum_match;
  logic [1:0] verdict;
  logic [2:0] command_code;

  assign is_dollar  = (byte_in == xcfc_pkg::CH_DOLLAR);
  assign is_nl      = (byte_in == xcfc_pkg::CH_NL);
  assign body_full  = (body_count == xcfc_pkg::BODY_W'(xcfc_pkg::MAX_BODY));
  assign in_prefix  = (body_count < xcfc_pkg::BODY_W'(xcfc_pkg::WORD_LEN));
  assign char_index = body_count[2:0];
  assign char_shift = {3'(3'd4 - char_index), 3'b000};

  // A newline inside an open frame closes it with one result.
  assign close_hit = in_frame && is_nl;

  // Verdict from the current state, overflow first.
  assign sum_match = (hex_high_char == xcfc_pkg::hex_char(xor_accumulator[7:4])) &&
                     (hex_low_char == xcfc_pkg::hex_char(xor_accumulator[3:0]));

  always_comb begin
    if (overflowed) begin
      verdict = xcfc_pkg::VERDICT_OVERFLOW;
    end else if (!star_seen) begin
      verdict = xcfc_pkg::VERDICT_NO_STAR;
    end else if (!sum_match) begin
      verdict = xcfc_pkg::VERDICT_BAD_SUM;
    end else begin
      verdict = xcfc_pkg::VERDICT_OK;
    end
  end

  // Command code: first surviving word, only for a good frame of full prefix.
  always_comb begin
    command_code = xcfc_pkg::CMD_NONE;
    if (verdict == xcfc_pkg::VERDICT_OK && !in_prefix) begin
      if (prefix_match_flags[0]) begin
        command_code = xcfc_pkg::CMD_PSIGN;
      end else if (prefix_match_flags[1]) begin
        command_code = xcfc_pkg::CMD_PFLSH;
      end else if (prefix_match_flags[2]) begin
        command_code = xcfc_pkg::CMD_PBLFL;
      end else if (prefix_match_flags[3]) begin
        command_code = xcfc_pkg::CMD_PEEPR;
      end
    end
  end

  assign result.verdict           = verdict;
  assign result.command_code      = command_code;
  assign result.body_length       = xcfc_pkg::LENGTH_W'(body_count);
  assign result.computed_checksum = xor_accumulator;

  // Next-state logic for one byte.
  always_comb begin
    in_frame_next           = in_frame;
    body_count_next         = body_count;
    xor_accumulator_next    = xor_accumulator;
    star_seen_next          = star_seen;
    after_star_count_next   = after_star_count;
    hex_high_char_next      = hex_high_char;
    hex_low_char_next       = hex_low_char;
    prefix_match_flags_next = prefix_match_flags;
    overflowed_next         = overflowed;

    if (is_dollar) begin
      in_frame_next           = 1'b1;
      body_count_next         = '0;
      xor_accumulator_next    = '0;
      star_seen_next          = 1'b0;
      after_star_count_next   = 2'd0;
      hex_high_char_next      = '0;
      hex_low_char_next       = '0;
      prefix_match_flags_next = '1;
      overflowed_next         = 1'b0;
    end else if (in_frame) begin
      if (is_nl) begin
        in_frame_next = 1'b0;
      end else if (body_full) begin
        overflowed_next = 1'b1;
      end else begin
        if (in_prefix) begin
          for (int k = 0; k < xcfc_pkg::NUM_WORDS; k++) begin
            if (xcfc_pkg::CMD_WORDS[k][char_shift +: 8] != byte_in) begin
              prefix_match_flags_next[k] = 1'b0;
            end
          end
        end
        body_count_next = body_count + 1'b1;
        if (!star_seen) begin
          if (byte_in == xcfc_pkg::CH_STAR) begin
            star_seen_next = 1'b1;
          end else begin
            xor_accumulator_next = xor_accumulator ^ byte_in;
          end
        end else if (after_star_count == 2'd0) begin
          hex_high_char_next    = byte_in;
          after_star_count_next = 2'd1;
        end else if (after_star_count == 2'd1) begin
          hex_low_char_next     = byte_in;
          after_star_count_next = 2'd2;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame           <= 1'b0;
      body_count         <= '0;
      xor_accumulator    <= '0;
      star_seen          <= 1'b0;
      after_star_count   <= 2'd0;
      hex_high_char      <= '0;
      hex_low_char       <= '0;
      prefix_match_flags <= '1;
      overflowed         <= 1'b0;
    end else if (step) begin
      in_frame           <= in_frame_next;
      body_count         <= body_count_next;
      xor_accumulator    <= xor_accumulator_next;
      star_seen          <= star_seen_next;
      after_star_count   <= after_star_count_next;
      hex_high_char      <= hex_high_char_next;
      hex_low_char       <= hex_low_char_next;
      prefix_match_flags <= prefix_match_flags_next;
      overflowed         <= overflowed_next;
    end
  end

endmodule

`default_nettype wire

>>> design/xcfc_result_reg.sv
`default_nettype none

module xcfc_result_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire xcfc_pkg::result_t result_in,
  input  wire logic              out_stall,
  output logic                   ready,
  output logic                   out_valid,
  output xcfc_pkg::result_t      result_out
);

  // The register can take a new result when empty or being drained.
  assign ready = !out_valid || !out_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  // Payload holds while stalled.
  always_ff @(posedge clk) begin
    if (ready && load) begin
      result_out <= result_in;
    end
  end

endmodule

`default_nettype wire

>>> design/xor_checksum_frame_checker_top.sv
// XOR checksum frame checker.
//
// Input channel: one received byte per transfer on rx_byte, in_valid and
// in_stall. Output channel: one verdict per closed frame on verdict,
// command_code, body_length and computed_checksum, with out_valid and
// out_stall. A '$' opens a frame, a newline inside a frame closes it and
// produces one result; all other bytes produce none.
// Throughput is one byte per cycle while in_stall is low: the byte goes into
// an input register, the frame tracker updates its state from it in one pass
// of short logic, and a closing byte loads the result register, which raises
// out_valid and holds the verdict until out_stall is low.
// When the receiver stalls with a result pending, bytes that produce no
// result keep flowing; a newline that closes a frame waits in the input
// register, and in_stall rises, until the result register drains.
// Reset (rst, synchronous, active high) empties both registers and leaves
// the tracker outside any frame.
`default_nettype none

module xor_checksum_frame_checker_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           verdict,
  output logic [2:0]                           command_code,
  output logic [xcfc_pkg::LENGTH_W-1:0]        body_length,
  output logic [7:0]                           computed_checksum
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              close_hit;
  logic              out_ready;
  logic              advance;
  xcfc_pkg::result_t tracker_result;
  xcfc_pkg::result_t out_result;

  // The staged byte moves on unless it closes a frame and the output is full.
  assign advance  = s1_valid && (!close_hit || out_ready);
  assign in_stall = s1_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  xcfc_frame_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .byte_in   (s1_byte),
    .close_hit (close_hit),
    .result    (tracker_result)
  );

  xcfc_result_reg u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && close_hit),
    .result_in  (tracker_result),
    .out_stall  (out_stall),
    .ready      (out_ready),
    .out_valid  (out_valid),
    .result_out (out_result)
  );

  assign verdict           = out_result.verdict;
  assign command_code      = out_result.command_code;
  assign body_length       = out_result.body_length;
  assign computed_checksum = out_result.computed_checksum;

  // A command code only comes with a good frame.
  a_code_only_when_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != xcfc_pkg::VERDICT_OK |-> command_code == xcfc_pkg::CMD_NONE)
    else $error("command code on a failed frame");

  // An overflowed frame reports the full capacity as its length.
  a_overflow_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == xcfc_pkg::VERDICT_OVERFLOW |->
      body_length == xcfc_pkg::LENGTH_W'(xcfc_pkg::MAX_BODY))
    else $error("overflow verdict without full body length");

  // A staged byte held back by the output keeps its value.
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> s1_valid && $stable(s1_byte))
    else $error("staged byte lost while stalled");

  // The input is only held back by a closing byte against a full output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> close_hit && out_valid && out_stall)
    else $error("input stalled without a pending result");

endmodule

`default_nettype wire
